[hw/rtl/ffd_pkg.sv]
// shared types and constants for the float frame tail deframer
// no dependencies; used by every rtl file of the block but ffd_ram
package ffd_pkg;

    localparam int BYTE_W          = 8;
    localparam int DATA_W          = 32;
    localparam int MAX_FRAME_WORDS = 64;
    localparam int ADDR_W          = $clog2(MAX_FRAME_WORDS);
    localparam int NUM_W           = $clog2(MAX_FRAME_WORDS + 1);
    localparam int CNT_W           = 9;
    localparam int TAIL_LEN        = 4;
    localparam logic [CNT_W-1:0]  CNT_MAX    = 9'd511;
    localparam logic [DATA_W-1:0] TAIL_RESET = 32'h7F80_0000;

    // apb register map, one word per register
    localparam int PADDR_W = 3;
    localparam logic REG_PAIR_MODE  = 1'b0;
    localparam logic REG_FRAME_TAIL = 1'b1;

    // what a closing tail does to the frame
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_WORDS = 2'd2;

    typedef struct packed {
        logic byte_take;
        logic rd_en;
        logic cap_a;
        logic cap_b;
        logic load_out;
    } t_ffd_cmd;

    typedef struct packed {
        logic [1:0] close_kind;
        logic       pair;
        logic       last;
        logic       out_free;
    } t_ffd_sts;

endpackage

[hw/rtl/ffd_byte_if.sv]
// byte stream channel: valid/ready handshake plus one raw byte
// depends on ffd_pkg
interface ffd_byte_if;
    logic                      valid;
    logic                      ready;
    logic [ffd_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

[hw/rtl/ffd_res_if.sv]
// result channel: valid/ready handshake plus one decoded result
// depends on ffd_pkg
interface ffd_res_if;
    logic                      valid;
    logic                      ready;
    logic [ffd_pkg::DATA_W-1:0] value_a;
    logic [ffd_pkg::DATA_W-1:0] value_b;
    logic                      last_of_frame;
    logic                      frame_empty;

    modport source (output valid, output value_a, output value_b,
                    output last_of_frame, output frame_empty, input ready);
    modport sink   (input valid, input value_a, input value_b,
                    input last_of_frame, input frame_empty, output ready);
endinterface

[hw/rtl/float_frame_tail_deframer_unit.sv]
// top level of the float frame tail deframer: apb registers, controller, datapath
// depends on ffd_pkg, ffd_byte_if, ffd_res_if, ffd_ctrl, ffd_datapath
//
//   channel    dir   modport   carries
//   i_byte     in    sink      in_byte
//   o_res      out   source    value_a, value_b, last_of_frame, frame_empty
//   apb        in    slave     pair_mode (0x0), frame_tail (0x4)
//
// one byte is taken per cycle while no frame is being read out
// a closing tail starts the readout: each word, or pair in pair mode, is read in
// turn through the single read port of the payload ram and its registered data
// bytes are stalled during readout; a result waiting in the output register
// does not stall bytes once the readout is over
// reset is synchronous and active low; no clearing pass on the payload ram
module float_frame_tail_deframer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ffd_byte_if.sink                       i_byte,
    ffd_res_if.source                      o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ffd_pkg::PADDR_W-1:0]    paddr,
    input  logic [ffd_pkg::DATA_W-1:0]     pwdata,
    output logic [ffd_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    logic                       r_pair_mode;
    logic [ffd_pkg::DATA_W-1:0] r_frame_tail;
    logic                       reg_sel;
    logic                       wr_en;

    ffd_pkg::t_ffd_cmd cmd;
    ffd_pkg::t_ffd_sts sts;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_mode  <= 1'b0;
            r_frame_tail <= ffd_pkg::TAIL_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                ffd_pkg::REG_PAIR_MODE:  r_pair_mode  <= pwdata[0];
                ffd_pkg::REG_FRAME_TAIL: r_frame_tail <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            ffd_pkg::REG_PAIR_MODE:  prdata = {{(ffd_pkg::DATA_W-1){1'b0}}, r_pair_mode};
            ffd_pkg::REG_FRAME_TAIL: prdata = r_frame_tail;
            default:                 prdata = '0;
        endcase
    end

    ffd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_byte.valid),
        .o_in_ready (i_byte.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_in_byte       (i_byte.in_byte),
        .i_pair_mode     (r_pair_mode),
        .i_frame_tail    (r_frame_tail),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_value_a       (o_res.value_a),
        .o_value_b       (o_res.value_b),
        .o_last_of_frame (o_res.last_of_frame),
        .o_frame_empty   (o_res.frame_empty)
    );

endmodule

[hw/rtl/ffd_ram.sv]
// generic simple dual port ram, one write and one read port, registered read
// no dependencies
module ffd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ffd_datapath.sv]
// deframer datapath: tail window, byte count, word assembly, payload ram,
// readout pointer and output register; depends on ffd_pkg and ffd_ram
module ffd_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ffd_pkg::t_ffd_cmd            i_cmd,
    output ffd_pkg::t_ffd_sts            o_sts,
    input  logic [ffd_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                         i_pair_mode,
    input  logic [ffd_pkg::DATA_W-1:0]   i_frame_tail,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [ffd_pkg::DATA_W-1:0]   o_value_a,
    output logic [ffd_pkg::DATA_W-1:0]   o_value_b,
    output logic                         o_last_of_frame,
    output logic                         o_frame_empty
);

    localparam int WIDX_W = ffd_pkg::CNT_W - 2;

    logic [ffd_pkg::CNT_W-1:0]  r_count;
    logic [ffd_pkg::DATA_W-1:0] r_recent;
    logic                       r_overflow;
    logic [ffd_pkg::DATA_W-1:0] r_word;
    logic [ffd_pkg::NUM_W-1:0]  r_left;
    logic [ffd_pkg::ADDR_W-1:0] r_addr;
    logic                       r_pair;
    logic                       r_empty;
    logic [ffd_pkg::DATA_W-1:0] r_a;
    logic [ffd_pkg::DATA_W-1:0] r_b;
    logic                       r_out_valid;
    logic [ffd_pkg::DATA_W-1:0] r_out_a;
    logic [ffd_pkg::DATA_W-1:0] r_out_b;
    logic                       r_out_last;
    logic                       r_out_empty;

    logic [ffd_pkg::CNT_W-1:0]  pos;
    logic [WIDX_W-1:0]          widx;
    logic                       has_byte;
    logic                       ovf_set;
    logic                       ovf_now;
    logic                       ram_we;
    logic [ffd_pkg::DATA_W-1:0] n_word;
    logic [ffd_pkg::DATA_W-1:0] n_recent;
    logic [ffd_pkg::CNT_W-1:0]  n_count;
    logic [ffd_pkg::CNT_W-1:0]  len;
    logic                       hit;
    logic [1:0]                 kind;
    logic [ffd_pkg::NUM_W-1:0]  num;
    logic [ffd_pkg::DATA_W-1:0] rdata;
    logic                       out_free;

    always_comb begin
        has_byte = r_count >= ffd_pkg::CNT_W'(ffd_pkg::TAIL_LEN);
        pos      = r_count - ffd_pkg::CNT_W'(ffd_pkg::TAIL_LEN);
        widx     = pos[ffd_pkg::CNT_W-1:2];
        ovf_set  = has_byte && (widx >= WIDX_W'(ffd_pkg::MAX_FRAME_WORDS));
        ovf_now  = r_overflow || ovf_set;
        // byte leaving the window lands on top, so the first byte ends up low
        n_word   = {r_recent[ffd_pkg::BYTE_W-1:0], r_word[ffd_pkg::DATA_W-1:ffd_pkg::BYTE_W]};
        ram_we   = i_cmd.byte_take && has_byte && !ovf_set && (pos[1:0] == 2'b11);
        n_recent = {i_in_byte, r_recent[ffd_pkg::DATA_W-1:ffd_pkg::BYTE_W]};
        n_count  = (r_count == ffd_pkg::CNT_MAX) ? r_count : r_count + 1'b1;
        hit      = (n_count >= ffd_pkg::CNT_W'(ffd_pkg::TAIL_LEN)) && (n_recent == i_frame_tail);
        len      = n_count - ffd_pkg::CNT_W'(ffd_pkg::TAIL_LEN);
        num      = i_pair_mode ? ffd_pkg::NUM_W'(len >> 3) : ffd_pkg::NUM_W'(len >> 2);
        kind     = ffd_pkg::KIND_NONE;
        if (hit && !ovf_now) begin
            if (len == '0) begin
                kind = ffd_pkg::KIND_EMPTY;
            end else if (!i_pair_mode && (len[1:0] == 2'b00)) begin
                kind = ffd_pkg::KIND_WORDS;
            end else if (i_pair_mode && (len[2:0] == 3'b000)) begin
                kind = ffd_pkg::KIND_WORDS;
            end
        end
        out_free = !r_out_valid || i_out_ready;
    end

    ffd_ram #(
        .WIDTH (ffd_pkg::DATA_W),
        .DEPTH (ffd_pkg::MAX_FRAME_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (widx[ffd_pkg::ADDR_W-1:0]),
        .i_wdata (n_word),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_recent    <= '0;
            r_overflow  <= 1'b0;
            r_left      <= '0;
            r_addr      <= '0;
            r_pair      <= 1'b0;
            r_empty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.byte_take) begin
                if (hit) begin
                    r_count    <= '0;
                    r_recent   <= '0;
                    r_overflow <= 1'b0;
                end else begin
                    r_count    <= n_count;
                    r_recent   <= n_recent;
                    r_overflow <= ovf_now;
                end
                if (kind != ffd_pkg::KIND_NONE) begin
                    r_left  <= (kind == ffd_pkg::KIND_EMPTY) ? ffd_pkg::NUM_W'(1) : num;
                    r_addr  <= '0;
                    r_pair  <= i_pair_mode;
                    r_empty <= (kind == ffd_pkg::KIND_EMPTY);
                end
            end
            if (i_cmd.rd_en) begin
                r_addr <= r_addr + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_left      <= r_left - 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_take && has_byte) begin
            r_word <= n_word;
        end
        if (i_cmd.byte_take && (kind != ffd_pkg::KIND_NONE)) begin
            r_a <= '0;
            r_b <= '0;
        end
        if (i_cmd.cap_a) begin
            r_a <= rdata;
        end
        if (i_cmd.cap_b) begin
            r_b <= rdata;
        end
        if (i_cmd.load_out) begin
            r_out_a     <= r_a;
            r_out_b     <= r_b;
            r_out_last  <= (r_left == ffd_pkg::NUM_W'(1));
            r_out_empty <= r_empty;
        end
    end

    assign o_sts.close_kind = kind;
    assign o_sts.pair       = r_pair;
    assign o_sts.last       = (r_left == ffd_pkg::NUM_W'(1));
    assign o_sts.out_free   = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_value_a       = r_out_a;
    assign o_value_b       = r_out_b;
    assign o_last_of_frame = r_out_last;
    assign o_frame_empty   = r_out_empty;

endmodule

[hw/rtl/ffd_ctrl.sv]
// deframer controller: takes bytes while idle, sequences the frame readout
// depends on ffd_pkg
module ffd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ffd_pkg::t_ffd_sts i_sts,
    output ffd_pkg::t_ffd_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDA  = 3'd1;
    localparam logic [2:0] S_CAPA = 3'd2;
    localparam logic [2:0] S_CAPB = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.byte_take = 1'b1;
                    if (i_sts.close_kind == ffd_pkg::KIND_EMPTY) begin
                        n_state = S_OUT;
                    end else if (i_sts.close_kind == ffd_pkg::KIND_WORDS) begin
                        n_state = S_RDA;
                    end
                end
            end
            S_RDA: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CAPA;
            end
            S_CAPA: begin
                o_cmd.cap_a = 1'b1;
                // second word of a pair follows straight behind the first
                if (i_sts.pair) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CAPB;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_CAPB: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = i_sts.last ? S_IDLE : S_RDA;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// self-checking bench for float_frame_tail_deframer_unit: byte stream in, decoded words out
// depends on ffd_pkg, ffd_byte_if, ffd_res_if and the rtl of the block
module tb_top;

    localparam int SETTLE       = 16;
    localparam int LIMIT_CYCLES = 3000000;
    localparam int DIR_N        = 29;

    typedef struct packed {
        logic [ffd_pkg::DATA_W-1:0] value_a;
        logic [ffd_pkg::DATA_W-1:0] value_b;
        logic                       last_of_frame;
        logic                       frame_empty;
    } t_frame_res;

    typedef enum logic [0:0] {ROW_BYTE, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        reg_idx;
        logic [31:0] value;
        logic        typed;
        t_frame_res  res;
    } t_dir_row;

    localparam t_frame_res NO_RES    = '0;
    localparam t_frame_res EMPTY_RES = {32'd0, 32'd0, 1'b1, 1'b1};

    // default tail arrives as 00 00 80 7f
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        // empty frame right after reset
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h00, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h00, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h80, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h7F, 1'b1, EMPTY_RES},
        // the window matches after three bytes, too early to close
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h00, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h80, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h7F, 1'b0, NO_RES},
        // closes with three payload bytes: dropped
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h00, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h00, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h80, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h7F, 1'b0, NO_RES},
        // eight bytes in single mode, mode flips before the tail
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h01, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h02, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h03, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h04, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h05, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h06, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h07, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h08, 1'b0, NO_RES},
        '{ROW_REG,  ffd_pkg::REG_PAIR_MODE,  32'h1,  1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h00, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h00, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h80, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'h7F, 1'b0, NO_RES},
        // all-ones tail, empty frame in pair mode
        '{ROW_REG,  ffd_pkg::REG_FRAME_TAIL, 32'hFFFF_FFFF, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'hFF, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'hFF, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'hFF, 1'b0, NO_RES},
        '{ROW_BYTE, ffd_pkg::REG_PAIR_MODE,  32'hFF, 1'b1, EMPTY_RES}
    };

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ffd_pkg::PADDR_W-1:0] paddr;
    logic [ffd_pkg::DATA_W-1:0]  pwdata;
    logic [ffd_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    ffd_byte_if byte_ch ();
    ffd_res_if  res_ch ();

    float_frame_tail_deframer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block's registers and frame state
    logic                       sh_pair = 1'b0;
    logic [ffd_pkg::DATA_W-1:0] sh_tail = ffd_pkg::TAIL_RESET;
    logic [ffd_pkg::DATA_W-1:0] sh_words [ffd_pkg::MAX_FRAME_WORDS];
    logic [ffd_pkg::CNT_W-1:0]  sh_cnt = '0;
    logic [ffd_pkg::DATA_W-1:0] sh_window = '0;
    logic                       sh_ovf = 1'b0;

    t_frame_res awaited_results [$];
    t_frame_res fresh_results [$];

    int src_idle = 0;
    int snk_idle = 0;
    int bytes_sent = 0;
    int errors = 0;
    int cycle_count = 0;
    int hold_len = 0;
    int hold_left = 0;
    bit hold_go = 1'b0;
    bit hold_seen = 1'b0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // advance the shadow frame by one byte; closing tails leave results in fresh_results
    function automatic void deframe_byte(input logic [7:0] b);
        int unsigned pos;
        int unsigned len;
        int unsigned i;
        logic last;
        fresh_results.delete();
        if (sh_cnt >= ffd_pkg::TAIL_LEN) begin
            pos = sh_cnt - ffd_pkg::TAIL_LEN;
            if ((pos >> 2) >= ffd_pkg::MAX_FRAME_WORDS)
                sh_ovf = 1'b1;
            else if (pos % 4 == 0)
                sh_words[pos >> 2] = {24'd0, sh_window[7:0]};
            else
                sh_words[pos >> 2][8 * (pos % 4) +: 8] = sh_window[7:0];
        end
        sh_window = {b, sh_window[31:8]};
        if (sh_cnt != ffd_pkg::CNT_MAX)
            sh_cnt++;
        if (sh_cnt < ffd_pkg::TAIL_LEN || sh_window != sh_tail)
            return;
        len = sh_cnt - ffd_pkg::TAIL_LEN;
        if (!sh_ovf) begin
            if (len == 0) begin
                fresh_results.push_back(EMPTY_RES);
            end else if (!sh_pair && len % 4 == 0) begin
                for (i = 0; i < len / 4; i++) begin
                    last = (i + 1 == len / 4);
                    fresh_results.push_back({sh_words[i], 32'd0, last, 1'b0});
                end
            end else if (sh_pair && len % 8 == 0) begin
                for (i = 0; i < len / 8; i++) begin
                    last = (i + 1 == len / 8);
                    fresh_results.push_back({sh_words[2*i], sh_words[2*i+1], last, 1'b0});
                end
            end
        end
        sh_cnt = '0;
        sh_window = '0;
        sh_ovf = 1'b0;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input t_frame_res typed_res = NO_RES);
        while ($urandom_range(99) < src_idle) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready)
            @(posedge i_clk);
        bytes_sent++;
        deframe_byte(b);
        if (typed)
            awaited_results.push_back(typed_res);
        else
            foreach (fresh_results[k])
                awaited_results.push_back(fresh_results[k]);
    endtask

    task automatic send_frame(input int payload_len);
        int k;
        for (k = 0; k < payload_len; k++)
            send_byte($urandom_range(255));
        for (k = 0; k < ffd_pkg::TAIL_LEN; k++)
            send_byte(sh_tail[8*k +: 8]);
    endtask

    // stop offering bytes until every result is out, then let the block go quiet
    task automatic settle_idle();
        byte_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (awaited_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == ffd_pkg::REG_PAIR_MODE)
            sh_pair = value[0];
        else
            sh_tail = value;
        @(posedge i_clk);
    endtask

    task automatic start_phase(input int src, input int snk, input logic pair,
                               input logic [31:0] tail);
        settle_idle();
        src_idle = src;
        snk_idle = snk;
        write_reg(ffd_pkg::REG_PAIR_MODE, {31'd0, pair});
        write_reg(ffd_pkg::REG_FRAME_TAIL, tail);
    endtask

    // mostly whole frames sized for the mode, some empty or misaligned ones, stray bytes and cut tails
    task automatic run_traffic(input int budget);
        int stop_at;
        int pick;
        int k;
        int n;
        int unit;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            unit = sh_pair ? 8 : 4;
            if (pick < 8) begin
                send_frame(0);
            end else if (pick < 72) begin
                send_frame(unit * $urandom_range(1, 4));
            end else if (pick < 86) begin
                send_frame($urandom_range(1, 47));
            end else if (pick < 93) begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++)
                    send_byte($urandom_range(255));
            end else begin
                // a tail cut short
                n = $urandom_range(1, ffd_pkg::TAIL_LEN - 1);
                for (k = 0; k < n; k++)
                    send_byte(sh_tail[8*k +: 8]);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_seen != hold_go) begin
            hold_seen = hold_go;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge i_clk) begin : res_monitor
        t_frame_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t result with none awaited: expected none actual %h %h %b %b",
                         $time, res_ch.value_a, res_ch.value_b, res_ch.last_of_frame,
                         res_ch.frame_empty);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                compare_field("value_a", want.value_a, res_ch.value_a);
                compare_field("value_b", want.value_b, res_ch.value_b);
                compare_field("last_of_frame", want.last_of_frame, res_ch.last_of_frame);
                compare_field("frame_empty", want.frame_empty, res_ch.frame_empty);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int k;
        i_rst_n         <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle = 36;
        snk_idle = 46;
        for (k = 0; k < DIR_N; k++) begin
            if (DIR_ROWS[k].kind == ROW_REG) begin
                settle_idle();
                write_reg(DIR_ROWS[k].reg_idx, DIR_ROWS[k].value);
            end else begin
                send_byte(DIR_ROWS[k].value[7:0], DIR_ROWS[k].typed, DIR_ROWS[k].res);
            end
        end

        start_phase(36, 46, 1'b0, ffd_pkg::TAIL_RESET);
        // long receiver stall while bytes keep coming
        hold_len = 300;
        hold_go  = ~hold_go;
        run_traffic(125);
        start_phase(46, 36, 1'b1, 32'h0000_0000);
        run_traffic(125);
        start_phase(0, 0, 1'($urandom_range(1)), $urandom());
        run_traffic(120);

        // full store, one byte past it, and a frame long enough to pin the count
        start_phase(0, 0, 1'b0, 32'hFFFF_FFFF);
        send_frame(ffd_pkg::MAX_FRAME_WORDS * 4);
        send_frame(ffd_pkg::MAX_FRAME_WORDS * 4 + 1);
        send_frame(600);
        start_phase(0, 0, 1'b1, $urandom());
        send_frame(ffd_pkg::MAX_FRAME_WORDS * 4);
        send_frame(ffd_pkg::MAX_FRAME_WORDS * 4 + 8);
        send_frame(16);

        settle_idle();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
hw/rtl/ffd_pkg.sv
hw/rtl/ffd_byte_if.sv
hw/rtl/ffd_res_if.sv
hw/rtl/ffd_ram.sv
hw/rtl/ffd_datapath.sv
hw/rtl/ffd_ctrl.sv
hw/rtl/float_frame_tail_deframer_unit.sv
tb/tb_top.sv
